>>> rtl/core/rgbb_pkg.sv
`default_nettype none
package rgbb_pkg;

  localparam int unsigned SumW = 20;

  typedef enum logic [0:0] {
    CmdPixel = 1'b0,
    CmdDrain = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    RegCols    = 3'd0,
    RegRows    = 3'd1,
    RegKTop    = 3'd2,
    RegKMid    = 3'd3,
    RegKBot    = 3'd4,
    RegDivisor = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StCalc,
    StOut
  } state_e;

endpackage
`default_nettype wire

>>> rtl/core/rgbb_ram.sv
`default_nettype none
module rgbb_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/core/rgbb_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, saturates to 255
module rgbb_div
  import rgbb_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [SumW-1:0]   num_i,
  input  wire [15:0]       den_i,
  output logic             done_o,
  output logic [7:0]       q_o
);
  logic [SumW-1:0] quo_q, quo_d;
  logic [15:0]     rem_q, rem_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [16:0]     trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[SumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = 5'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = 16'(trial - {1'b0, den_i});
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == 5'd1);
  assign q_o    = (quo_d[SumW-1:8] != '0) ? 8'hFF : quo_d[7:0];
endmodule
`default_nettype wire

>>> rtl/core/rgb_blur_3x3_window_core.sv
`default_nettype none
// an accepted beat goes to StRead, which shifts the window from the line stores, then to
// StCalc, which launches the bit-serial dividers (three channels in parallel dividers); a
// result is registered when they finish and held in StOut until taken, then StCalc launches
// any second result; no new beat is accepted until every result of the last one is taken
// reset: window, positions and registers to reset values; line stores are
// left undefined until written, no clearing pass
module rgb_blur_3x3_window_core
  import rgbb_pkg::*;
#(
  parameter int unsigned MAX_COLS = 1024
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [23:0] s_axis_tdata,  // red_in, green_in, blue_in
  input  wire         s_axis_tuser,  // command
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata,  // red_out, green_out, blue_out
  output logic        m_axis_tlast,  // last_of_run
  output logic        m_axis_tuser,  // frame_end
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_idx_i,
  input  wire  [23:0] cfg_data_i
);
  localparam int unsigned AW = $clog2(MAX_COLS);
  localparam int unsigned CW = $clog2(MAX_COLS + 1);

  logic [10:0] cols_q;
  logic [15:0] rows_q, div_q;
  logic [2:0][23:0] kern_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 11'd1024;
      rows_q <= 16'd768;
      kern_q <= {24'd66049, 24'd132098, 24'd66049};
      div_q  <= 16'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegCols:    cols_q    <= cfg_data_i[10:0];
        RegRows:    rows_q    <= cfg_data_i[15:0];
        RegKTop:    kern_q[0] <= cfg_data_i;
        RegKMid:    kern_q[1] <= cfg_data_i;
        RegKBot:    kern_q[2] <= cfg_data_i;
        RegDivisor: div_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CW-1:0] cols_eff;
  logic [15:0]   rows_eff, div_eff;
  always_comb begin
    if (cols_q == '0) cols_eff = CW'(1);
    else if ({5'd0, cols_q} > 16'(MAX_COLS)) cols_eff = CW'(MAX_COLS);
    else cols_eff = CW'(cols_q);
    rows_eff = (rows_q == '0) ? 16'd1 : rows_q;
    div_eff  = (div_q == '0) ? 16'd1 : div_q;
  end

  state_e st_q, st_d;
  logic [15:0]   row_q;
  logic [CW-1:0] col_q;
  logic [2:0][2:0][23:0] win_q;
  logic [23:0]   pix_q;
  logic          drain_q;
  logic [AW-1:0] c_q;
  logic          emit_q;   // pending first result (centre column 1)
  logic          emit2_q;  // pending last-column result
  logic          top_ok_q, left1_q, left2_q;

  logic [23:0] up_rd, lo_rd;
  logic        ram_we;

  logic drain_now, acc;
  logic [CW-1:0] c_now;
  logic [AW-1:0] rd_addr;

  // while idle the stores are read at the column of the next beat
  assign rd_addr = (st_q == StIdle) ? c_now[AW-1:0] : c_q;

  rgbb_ram #(.Width(24), .Depth(MAX_COLS)) u_upper (
    .clk_i, .we_i(ram_we), .waddr_i(c_q), .wdata_i(lo_rd),
    .raddr_i(rd_addr), .rdata_o(up_rd)
  );
  rgbb_ram #(.Width(24), .Depth(MAX_COLS)) u_lower (
    .clk_i, .we_i(ram_we), .waddr_i(c_q), .wdata_i(pix_q),
    .raddr_i(rd_addr), .rdata_o(lo_rd)
  );

  assign drain_now = row_q >= rows_eff;
  assign c_now     = (col_q >= cols_eff) ? cols_eff - CW'(1) : col_q;
  assign s_axis_tready = (st_q == StIdle);
  assign acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser == drain_now);
  assign ram_we = (st_q == StRead) && !drain_q;

  // sums for centre column k
  function automatic logic [2:0][SumW-1:0] blur(
    input logic [2:0][2:0][23:0] w, input logic [2:0][23:0] kr,
    input logic k2, input logic l_ok, input logic r_ok,
    input logic t_ok, input logic b_ok);
    logic [2:0][SumW-1:0] s;
    logic [23:0] px, cen;
    logic ok;
    logic [1:0] col;
    cen = k2 ? w[1][2] : w[1][1];
    for (int ch = 0; ch < 3; ch++) begin
      s[ch] = '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ok = !((i == 0 && !t_ok) || (i == 2 && !b_ok) ||
                 (j == 0 && !l_ok) || (j == 2 && !r_ok));
          col = k2 ? ((j == 0) ? 2'd1 : 2'd2) : 2'(j);
          px = ok ? w[i][col] : cen;
          s[ch] = s[ch] + SumW'(px[ch*8 +: 8] * kr[i][j*8 +: 8]);
        end
      end
    end
    return s;
  endfunction

  logic [2:0][SumW-1:0] sums_q;
  logic                 last_q, fend_q;
  logic                 dstart;
  logic [2:0]           ddone;
  logic [2:0][7:0]      dq;

  for (genvar g = 0; g < 3; g++) begin : g_div
    rgbb_div u_div (
      .clk_i, .rst_ni, .start_i(dstart), .num_i(sums_q[g]), .den_i(div_eff),
      .done_o(ddone[g]), .q_o(dq[g])
    );
  end

  logic busy_q;
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (acc) st_d = StRead;
      StRead: st_d = StCalc;
      StCalc: begin
        if (!emit_q && !emit2_q) st_d = StIdle;
        else st_d = StOut;
      end
      StOut: if (m_axis_tvalid && m_axis_tready) st_d = StCalc;
      default: st_d = StIdle;
    endcase
  end

  assign dstart = (st_q == StCalc) && (emit_q || emit2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      row_q <= '0;
      col_q <= '0;
      win_q <= '0;
      emit_q <= 1'b0;
      emit2_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
      busy_q <= 1'b0;
      c_q <= '0;
      drain_q <= 1'b0;
      pix_q <= '0;
      top_ok_q <= 1'b0;
      left1_q <= 1'b0;
      left2_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (acc) begin
        logic lst;
        lst = (c_now == cols_eff - CW'(1));
        c_q      <= c_now[AW-1:0];
        drain_q  <= s_axis_tuser;
        pix_q    <= s_axis_tuser ? 24'd0 : s_axis_tdata;
        top_ok_q <= row_q >= 16'd2;
        left1_q  <= c_now >= CW'(2);
        left2_q  <= c_now >= CW'(1);
        emit_q   <= (row_q != '0) && (c_now >= CW'(1));
        emit2_q  <= (row_q != '0) && lst;
        if (lst) begin
          col_q <= '0;
          row_q <= s_axis_tuser ? 16'd0 : row_q + 16'd1;
        end else begin
          col_q <= c_now + CW'(1);
        end
      end
      if (st_q == StRead) begin
        for (int i = 0; i < 3; i++) begin
          win_q[i][0] <= win_q[i][1];
          win_q[i][1] <= win_q[i][2];
        end
        win_q[0][2] <= up_rd;
        win_q[1][2] <= lo_rd;
        win_q[2][2] <= pix_q;
      end
      if (dstart) begin
        busy_q <= 1'b1;
        if (emit_q) emit_q <= 1'b0;
        else emit2_q <= 1'b0;
      end
      if (busy_q && ddone[0]) begin
        busy_q <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // capture sums and flags as the job is launched
  logic [2:0][SumW-1:0] s1, s2;
  assign s1 = blur(win_q, kern_q, 1'b0, left1_q, 1'b1, top_ok_q, !drain_q);
  assign s2 = blur(win_q, kern_q, 1'b1, left2_q, 1'b0, top_ok_q, !drain_q);

  always_ff @(posedge clk_i) begin
    if (st_q == StRead || (st_q == StOut && m_axis_tvalid && m_axis_tready)) begin
      // sums are taken next cycle in StCalc from the updated window
    end
    if (st_q == StCalc && (emit_q || emit2_q)) begin
      last_q <= !(emit_q && emit2_q);
      fend_q <= !emit_q && drain_q;
    end
    if (busy_q && ddone[0]) begin
      m_axis_tdata <= {dq[2], dq[1], dq[0]};
      m_axis_tlast <= last_q;
      m_axis_tuser <= fend_q;
    end
  end

  assign sums_q = emit_q ? s1 : s2;
endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rgbb_pkg::*;

  localparam int unsigned MaxCols = 1024;
  localparam int unsigned TailCycles = 80;
  localparam longint unsigned CycleLimit = 500_000;

  typedef struct packed {
    logic [23:0] rgb;
    logic        last;
    logic        fend;
  } blur_beat_t;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cmd_e        cmd;
    reg_e        idx;
    logic [23:0] val;
    bit          typed;
    logic [23:0] want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // red_in, green_in, blue_in
  logic        s_axis_tuser;   // command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // red_out, green_out, blue_out
  logic        m_axis_tlast;   // last_of_run
  logic        m_axis_tuser;   // frame_end
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [23:0] cfg_data_i;

  rgb_blur_3x3_window_core #(.MAX_COLS(MaxCols)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // blur predictor state
  logic [23:0] upper_line [MaxCols];
  logic [23:0] lower_line [MaxCols];
  logic [23:0] win [3][3];
  logic [15:0] row_pos;
  int unsigned col_pos;
  logic [10:0] cols_r;
  logic [15:0] rows_r;
  logic [23:0] kern_r [3];
  logic [15:0] div_r;

  blur_beat_t  pending_blur[$];
  stim_row_t   stim_tbl[$];
  int          n_err, n_items, n_beats, n_frames, n_ignored;
  bit          tx_burst, rx_burst;
  int          hold_req;
  longint unsigned cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report(string what, blur_beat_t got, blur_beat_t want);
    n_err++;
    $display("mismatch %s: got rgb=%h last=%b fend=%b, want rgb=%h last=%b fend=%b",
             what, got.rgb, got.last, got.fend, want.rgb, want.last, want.fend);
  endtask

  function automatic logic [23:0] blur_px(int k, bit l_ok, bit r_ok, bit t_ok, bit b_ok);
    logic [23:0] res;
    logic [23:0] centre, px;
    int unsigned sum, q, w, d, col;
    centre = win[1][k];
    d = (div_r == 0) ? 1 : div_r;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          w = (kern_r[i] >> (8 * j)) & 8'hFF;
          col = (k + j - 1 > 2) ? 2 : k + j - 1;
          px = win[i][col];
          if ((i == 0 && !t_ok) || (i == 2 && !b_ok) || (j == 0 && !l_ok) ||
              (j == 2 && !r_ok)) px = centre;
          sum += ((px >> (8 * ch)) & 8'hFF) * w;
        end
      end
      q = sum / d;
      res[8*ch +: 8] = (q > 255) ? 8'hFF : q[7:0];
    end
    return res;
  endfunction

  // returns number of result beats queued, -1 when the item is ignored
  function automatic int predict_blur(cmd_e cmd, logic [23:0] pix);
    int unsigned cols, rows, c;
    bit drain, last;
    int n;
    blur_beat_t b;
    cols = (cols_r == 0) ? 1 : cols_r;
    if (cols > MaxCols) cols = MaxCols;
    rows = (rows_r == 0) ? 1 : rows_r;
    drain = (row_pos >= rows);
    if ((cmd == CmdDrain) != drain) return -1;
    c = (col_pos >= cols) ? cols - 1 : col_pos;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[c];
    win[1][2] = lower_line[c];
    win[2][2] = drain ? 24'h0 : pix;
    if (!drain) begin
      upper_line[c] = lower_line[c];
      lower_line[c] = pix;
    end
    last = (c == cols - 1);
    n = 0;
    if (row_pos >= 1) begin
      if (c >= 1) begin
        b.rgb = blur_px(1, c >= 2, 1'b1, row_pos >= 2, !drain);
        b.last = !last;
        b.fend = 1'b0;
        pending_blur.insert(pending_blur.size(), b);
        n++;
      end
      if (last) begin
        b.rgb = blur_px(2, c >= 1, 1'b0, row_pos >= 2, !drain);
        b.last = 1'b1;
        b.fend = drain;
        pending_blur.insert(pending_blur.size(), b);
        n++;
      end
    end
    if (last) begin
      col_pos = 0;
      row_pos = drain ? 16'd0 : row_pos + 16'd1;
      if (drain) n_frames++;
    end else begin
      col_pos = c + 1;
    end
    return n;
  endfunction

  task automatic send_item(cmd_e cmd, logic [23:0] pix, bit typed = 1'b0,
                           logic [23:0] want = '0);
    int gap, n;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    n = predict_blur(cmd, pix);
    if (n < 0) n_ignored++;
    else n_items++;
    if (typed)
      for (int i = 0; i < n; i++)
        pending_blur[pending_blur.size() - 1 - i].rgb = want;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // caller must be idle; cfg_we_i is dropped by cfg_done
  task automatic write_reg(reg_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegCols:    cols_r = val[10:0];
      RegRows:    rows_r = val[15:0];
      RegKTop:    kern_r[0] = val;
      RegKMid:    kern_r[1] = val;
      RegKBot:    kern_r[2] = val;
      RegDivisor: div_r = val[15:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [23:0] rand_px();
    case ($urandom_range(0, 9))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [23:0] rand_kernel();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h010201;
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic run_frame(logic [10:0] cols, logic [15:0] rows, bit noisy);
    int unsigned nc, nr;
    wait_idle();
    write_reg(RegCols, 24'(cols));
    write_reg(RegRows, 24'(rows));
    write_reg(RegKTop, rand_kernel());
    write_reg(RegKMid, rand_kernel());
    write_reg(RegKBot, rand_kernel());
    case ($urandom_range(0, 5))
      0: write_reg(RegDivisor, 24'($urandom_range(0, 65535)));
      1: write_reg(RegDivisor, 24'd1);
      default: write_reg(RegDivisor, 24'($urandom_range(1, 200)));
    endcase
    cfg_done();
    tx_burst = ($urandom_range(0, 3) == 0);
    nc = (cols == 0) ? 1 : (cols > MaxCols ? MaxCols : cols);
    nr = (rows == 0) ? 1 : rows;
    for (int r = 0; r <= nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        // out-of-place commands are dropped by the block
        if (noisy && $urandom_range(0, 9) == 0)
          send_item(r == nr ? CmdPixel : CmdDrain, rand_px());
        send_item(r == nr ? CmdDrain : CmdPixel, rand_px());
      end
    end
  endtask

  task automatic row_item(cmd_e cmd, logic [23:0] pix, bit typed = 1'b0,
                          logic [23:0] want = '0);
    stim_row_t r;
    r.kind = RowItem; r.cmd = cmd; r.idx = RegCols; r.val = pix;
    r.typed = typed; r.want = want;
    stim_tbl.insert(stim_tbl.size(), r);
  endtask

  task automatic row_cfg(reg_e idx, logic [23:0] val);
    stim_row_t r;
    r.kind = RowCfg; r.cmd = CmdPixel; r.idx = idx; r.val = val;
    r.typed = 1'b0; r.want = '0;
    stim_tbl.insert(stim_tbl.size(), r);
  endtask

  // receiver with random stalls and an occasional long hold-off
  initial begin
    int rx_wait, hold;
    blur_beat_t got, want;
    m_axis_tready = 1'b0;
    rx_wait = 0;
    hold = 0;
    rx_burst = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold = hold_req;
        hold_req = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata, m_axis_tlast, m_axis_tuser};
        n_beats++;
        if (n_beats % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
        if (pending_blur.size() == 0) begin
          report("unexpected beat", got, '0);
        end else begin
          want = pending_blur.pop_front();
          if (got.rgb[7:0] !== want.rgb[7:0]) report("red", got, want);
          if (got.rgb[15:8] !== want.rgb[15:8]) report("green", got, want);
          if (got.rgb[23:16] !== want.rgb[23:16]) report("blue", got, want);
          if (got.last !== want.last) report("tlast", got, want);
          if (got.fend !== want.fend) report("frame end", got, want);
        end
        rx_wait = rx_burst ? 0 : $urandom_range(0, 13);
      end
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    row_pos = 0; col_pos = 0;
    cols_r = 11'd1024; rows_r = 16'd768; div_r = 16'd16;
    kern_r[0] = 24'h010201; kern_r[1] = 24'h020402; kern_r[2] = 24'h010201;
    foreach (win[i, j]) win[i][j] = '0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    n_err = 0; n_items = 0; n_beats = 0; n_frames = 0; n_ignored = 0;
    hold_req = 0; cycle_cnt = 0; tx_burst = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // 2x1 frame of white then black; all-flat windows give the pixel back
    row_cfg(RegCols, 24'd2); row_cfg(RegRows, 24'd1);
    row_cfg(RegKTop, 24'h010201); row_cfg(RegKMid, 24'h020402);
    row_cfg(RegKBot, 24'h010201); row_cfg(RegDivisor, 24'd16);
    row_item(CmdPixel, 24'hFFFFFF); row_item(CmdPixel, 24'hFFFFFF);
    row_item(CmdPixel, 24'h123456);     // pixel in drain row, dropped
    row_item(CmdDrain, 24'h0); row_item(CmdDrain, 24'h0, 1'b1, 24'hFFFFFF);
    row_item(CmdPixel, 24'h000000);
    row_item(CmdDrain, 24'h0);          // drain inside frame, dropped
    row_item(CmdPixel, 24'h000000);
    row_item(CmdDrain, 24'h0); row_item(CmdDrain, 24'h0, 1'b1, 24'h000000);
    // zero geometry acts as 1x1
    row_cfg(RegCols, 24'd0); row_cfg(RegRows, 24'd0);
    row_item(CmdPixel, 24'h8040C0); row_item(CmdDrain, 24'h0);
    // heaviest kernel, zero divisor: saturates
    row_cfg(RegCols, 24'd2); row_cfg(RegRows, 24'd1);
    row_cfg(RegKTop, 24'hFFFFFF); row_cfg(RegKMid, 24'hFFFFFF);
    row_cfg(RegKBot, 24'hFFFFFF); row_cfg(RegDivisor, 24'd0);
    row_item(CmdPixel, 24'hFFFFFF); row_item(CmdPixel, 24'h010101);
    row_item(CmdDrain, 24'h0); row_item(CmdDrain, 24'h0, 1'b1, 24'hFFFFFF);
    // geometry shrunk mid-frame
    row_cfg(RegDivisor, 24'h00FFFF); row_cfg(RegDivisor, 24'd16);
    row_cfg(RegKTop, 24'h030201); row_cfg(RegKMid, 24'h050804);
    row_cfg(RegKBot, 24'h020107);
    row_cfg(RegCols, 24'd4); row_cfg(RegRows, 24'd3);
    for (int i = 0; i < 6; i++) row_item(CmdPixel, 24'(24'h2040F0 + i * 24'h0B1315));
    row_cfg(RegCols, 24'd2);
    row_item(CmdPixel, 24'hA05010);
    row_cfg(RegRows, 24'd1);
    row_item(CmdDrain, 24'h0); row_item(CmdDrain, 24'h0);
    // tallest frame, cut short once three rows are in
    row_cfg(RegCols, 24'd1); row_cfg(RegRows, 24'h00FFFF);
    row_item(CmdPixel, 24'h102030); row_item(CmdPixel, 24'hF0E0D0);
    row_item(CmdPixel, 24'h7F807F);
    row_cfg(RegRows, 24'd1);
    row_item(CmdDrain, 24'h0);

    foreach (stim_tbl[i]) begin
      if (stim_tbl[i].kind == RowCfg) begin
        if (i == 0 || stim_tbl[i - 1].kind != RowCfg) wait_idle();
        write_reg(stim_tbl[i].idx, stim_tbl[i].val);
        if (i == stim_tbl.size() - 1 || stim_tbl[i + 1].kind != RowCfg) cfg_done();
      end else begin
        send_item(stim_tbl[i].cmd, stim_tbl[i].val, stim_tbl[i].typed, stim_tbl[i].want);
      end
    end

    while (n_items < 480) begin
      if ($urandom_range(0, 7) == 0)
        run_frame(11'($urandom_range(9, 40)), 16'($urandom_range(1, 4)), 1'b1);
      else
        run_frame(11'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
                  1'($urandom_range(0, 1)));
      // long receiver hold-off while the sender keeps pushing
      if (n_frames == 12) begin
        wait_idle();
        write_reg(RegCols, 24'd6); write_reg(RegRows, 24'd4); cfg_done();
        hold_req = 400;
        tx_burst = 1;
        for (int r = 0; r <= 4; r++)
          for (int c = 0; c < 6; c++) send_item(r == 4 ? CmdDrain : CmdPixel, rand_px());
      end
    end

    wait_idle();
    $display("covered %0d items (%0d dropped) over %0d frames, %0d result beats checked",
             n_items, n_ignored, n_frames, n_beats);
    if (n_err == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d mismatches", n_err);
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
